FILE: rtl/pwnp_pkg.sv
// Shared types, constants and helper functions for the PID step unit.
package pwnp_pkg;

	localparam int DW = 32;
	localparam int FW = 24;
	localparam int ACC_W = 44;
	localparam int PROD_W = 64;
	localparam int ANG_W = 40;
	localparam int CW = 34;
	localparam int CORDIC_STEPS = 24;
	localparam int STEP_W = 5;
	localparam int IDX_W = 3;
	localparam int ANG_SHIFT = 6;

	typedef logic signed [DW-1:0] data_t;
	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [ANG_W-1:0] ang_t;
	typedef logic signed [CW-1:0] cord_t;

	localparam logic [IDX_W-1:0] REG_GAIN_Q0 = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_Q1 = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_Q2 = 3'd2;
	localparam logic [IDX_W-1:0] REG_PLANT_A = 3'd3;
	localparam logic [IDX_W-1:0] REG_PLANT_B = 3'd4;
	localparam logic [IDX_W-1:0] REG_PLANT_C = 3'd5;
	localparam logic [IDX_W-1:0] REG_PLANT_D = 3'd6;

	localparam data_t RST_GAIN_Q0 = 32'sd169450;
	localparam data_t RST_GAIN_Q1 = -32'sd337206;
	localparam data_t RST_GAIN_Q2 = 32'sd167772;
	localparam data_t RST_PLANT_A = 32'sd12113150;
	localparam data_t RST_PLANT_B = 32'sd7063208;
	localparam data_t RST_PLANT_C = 32'sd9848226;
	localparam data_t RST_PLANT_D = 32'sd587203;
	localparam data_t RST_DRIVE = 32'sd16777216;

	localparam ang_t TWO_PI_Q30 = 40'sd6746518852;
	localparam ang_t PI_Q30 = 40'sd3373259426;
	localparam ang_t HALF_PI_Q30 = 40'sd1686629713;
	localparam ang_t ANG_OFFSET = 40'sd215888603264;
	localparam cord_t CORDIC_GAIN = 34'sd652032874;
	localparam cord_t SIN_ONE = 34'sd16777216;
	localparam cord_t SIN_RND_BIAS = 34'sd32;

	localparam acc_t ACC_MAX = 44'sd2147483647;
	localparam acc_t ACC_MIN = -44'sd2147483648;
	localparam prod_t ROUND_HALF = 64'sd8388608;

	typedef enum logic [2:0] {
		OP_Q0E0,
		OP_Q1E1,
		OP_Q2E2,
		OP_H1H1,
		OP_AH0,
		OP_BSQ,
		OP_CU,
		OP_DS
	} mul_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_DONE
	} ctrl_state_t;

	typedef enum logic [2:0] {
		SIN_IDLE,
		SIN_REDUCE,
		SIN_FOLD,
		SIN_ROTATE,
		SIN_ROUND,
		SIN_DONE
	} sin_state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic acc;
		logic commit;
		mul_op_t op;
	} ctrl_cmd_t;

	typedef struct packed {
		logic sin_done;
		logic out_free;
	} dp_status_t;

	function automatic acc_t sext_data(input data_t x);
		return {{(ACC_W-DW){x[DW-1]}}, x};
	endfunction

	function automatic logic sat_ovf(input acc_t x);
		return (x > ACC_MAX) || (x < ACC_MIN);
	endfunction

	function automatic data_t sat_data(input acc_t x);
		acc_t r;
		r = x;
		if (x > ACC_MAX) begin
			r = ACC_MAX;
		end else if (x < ACC_MIN) begin
			r = ACC_MIN;
		end
		return r[DW-1:0];
	endfunction

	function automatic cord_t atan_q30(input logic [STEP_W-1:0] i);
		cord_t r;
		case (i)
			5'd0: r = 34'sd843314856;
			5'd1: r = 34'sd497837829;
			5'd2: r = 34'sd263043836;
			5'd3: r = 34'sd133525158;
			5'd4: r = 34'sd67021686;
			5'd5: r = 34'sd33543515;
			5'd6: r = 34'sd16775850;
			5'd7: r = 34'sd8388437;
			5'd8: r = 34'sd4194282;
			5'd9: r = 34'sd2097149;
			5'd10: r = 34'sd1048575;
			5'd11: r = 34'sd524287;
			5'd12: r = 34'sd262143;
			5'd13: r = 34'sd131071;
			5'd14: r = 34'sd65535;
			5'd15: r = 34'sd32767;
			5'd16: r = 34'sd16383;
			5'd17: r = 34'sd8191;
			5'd18: r = 34'sd4095;
			5'd19: r = 34'sd2047;
			5'd20: r = 34'sd1023;
			5'd21: r = 34'sd511;
			5'd22: r = 34'sd255;
			5'd23: r = 34'sd127;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/pwnp_sin.sv
// Iterative sine unit: modulo-two-pi reduction, quadrant fold and a CORDIC rotation.
module pwnp_sin
	import pwnp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  data_t angle,
	output logic  done,
	output data_t result
);

	sin_state_t state_q, state_d;
	logic [2:0] k_q;
	logic [STEP_W-1:0] i_q;
	ang_t z_q;
	cord_t x_q, y_q, cz_q;
	data_t res_q;

	ang_t sub_val;
	ang_t fold_a, fold_b;
	cord_t dx, dy, atan_v;
	cord_t rnd, clamped;

	always_comb begin
		state_d = state_q;
		if (start) begin
			state_d = SIN_REDUCE;
		end else begin
			case (state_q)
				SIN_REDUCE: if (k_q == 3'd0) state_d = SIN_FOLD;
				SIN_FOLD: state_d = SIN_ROTATE;
				SIN_ROTATE: if (i_q == STEP_W'(CORDIC_STEPS - 1)) state_d = SIN_ROUND;
				SIN_ROUND: state_d = SIN_DONE;
				default: state_d = state_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SIN_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		done = (state_q == SIN_DONE);
	end

	assign result = res_q;

	assign sub_val = TWO_PI_Q30 <<< k_q;

	always_comb begin
		fold_a = z_q;
		if (z_q > PI_Q30) begin
			fold_a = z_q - TWO_PI_Q30;
		end
		fold_b = fold_a;
		if (fold_a > HALF_PI_Q30) begin
			fold_b = PI_Q30 - fold_a;
		end else if (fold_a < -HALF_PI_Q30) begin
			fold_b = -PI_Q30 - fold_a;
		end
	end

	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign atan_v = atan_q30(i_q);

	always_comb begin
		rnd = (y_q + SIN_RND_BIAS) >>> ANG_SHIFT;
		clamped = rnd;
		if (rnd > SIN_ONE) begin
			clamped = SIN_ONE;
		end else if (rnd < -SIN_ONE) begin
			clamped = -SIN_ONE;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			z_q <= {{(ANG_W-DW-ANG_SHIFT){angle[DW-1]}}, angle, {ANG_SHIFT{1'b0}}} + ANG_OFFSET;
			k_q <= 3'd5;
		end else begin
			case (state_q)
				SIN_REDUCE: begin
					if (z_q >= sub_val) z_q <= z_q - sub_val;
					k_q <= k_q - 3'd1;
				end
				SIN_FOLD: begin
					cz_q <= fold_b[CW-1:0];
					x_q <= CORDIC_GAIN;
					y_q <= '0;
					i_q <= '0;
				end
				SIN_ROTATE: begin
					if (!cz_q[CW-1]) begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						cz_q <= cz_q - atan_v;
					end else begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						cz_q <= cz_q + atan_v;
					end
					i_q <= i_q + STEP_W'(1);
				end
				SIN_ROUND: res_q <= clamped[DW-1:0];
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/pwnp_dp.sv
// Datapath: coefficient registers, loop history, shared multiplier, accumulator and output register.
module pwnp_dp
	import pwnp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  ctrl_cmd_t        cmd,
	output dp_status_t       status,
	input  data_t            setpoint,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  data_t            cfg_data,
	output logic             out_valid,
	input  logic             out_ready,
	output data_t            out_plant_output,
	output data_t            out_drive,
	output logic             out_overflow
);

	data_t gain_q0_q, gain_q1_q, gain_q2_q;
	data_t plant_a_q, plant_b_q, plant_c_q, plant_d_q;
	data_t hist0_q, hist1_q, hist2_q, prev_drive_q;
	data_t e0_q, e1_q, e2_q, u_q, sq_q, y_q;
	acc_t acc_q;
	logic ov_q;
	prod_t p_s1;
	logic out_valid_q;
	data_t out_y_q, out_u_q;
	logic out_ov_q;

	acc_t d0, d1, d2;
	data_t op_a, op_b;
	prod_t rnd_full;
	acc_t rnd, sum;
	logic sin_done;
	data_t sin_val;

	pwnp_sin u_sin (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.load),
		.angle  (prev_drive_q),
		.done   (sin_done),
		.result (sin_val)
	);

	assign status.sin_done = sin_done;
	assign status.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q0_q <= RST_GAIN_Q0;
			gain_q1_q <= RST_GAIN_Q1;
			gain_q2_q <= RST_GAIN_Q2;
			plant_a_q <= RST_PLANT_A;
			plant_b_q <= RST_PLANT_B;
			plant_c_q <= RST_PLANT_C;
			plant_d_q <= RST_PLANT_D;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN_Q0: gain_q0_q <= cfg_data;
				REG_GAIN_Q1: gain_q1_q <= cfg_data;
				REG_GAIN_Q2: gain_q2_q <= cfg_data;
				REG_PLANT_A: plant_a_q <= cfg_data;
				REG_PLANT_B: plant_b_q <= cfg_data;
				REG_PLANT_C: plant_c_q <= cfg_data;
				REG_PLANT_D: plant_d_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign d0 = sext_data(setpoint) - sext_data(hist0_q);
	assign d1 = sext_data(setpoint) - sext_data(hist1_q);
	assign d2 = sext_data(setpoint) - sext_data(hist2_q);

	always_comb begin
		case (cmd.op)
			OP_Q0E0: begin op_a = gain_q0_q; op_b = e0_q; end
			OP_Q1E1: begin op_a = gain_q1_q; op_b = e1_q; end
			OP_Q2E2: begin op_a = gain_q2_q; op_b = e2_q; end
			OP_H1H1: begin op_a = hist1_q; op_b = hist1_q; end
			OP_AH0: begin op_a = plant_a_q; op_b = hist0_q; end
			OP_BSQ: begin op_a = plant_b_q; op_b = sq_q; end
			OP_CU: begin op_a = plant_c_q; op_b = u_q; end
			OP_DS: begin op_a = plant_d_q; op_b = sin_val; end
			default: begin op_a = '0; op_b = '0; end
		endcase
	end

	assign rnd_full = (p_s1 + ROUND_HALF) >>> FW;
	assign rnd = rnd_full[ACC_W-1:0];
	assign sum = acc_q + rnd;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			p_s1 <= prod_t'(op_a) * prod_t'(op_b);
		end
		if (cmd.load) begin
			e0_q <= sat_data(d0);
			e1_q <= sat_data(d1);
			e2_q <= sat_data(d2);
			ov_q <= sat_ovf(d0) || sat_ovf(d1) || sat_ovf(d2);
			acc_q <= sext_data(prev_drive_q);
		end else if (cmd.acc) begin
			case (cmd.op)
				OP_Q0E0, OP_Q1E1, OP_CU: acc_q <= sum;
				OP_Q2E2: begin
					u_q <= sat_data(sum);
					ov_q <= ov_q || sat_ovf(sum);
				end
				OP_H1H1: begin
					sq_q <= sat_data(rnd);
					ov_q <= ov_q || sat_ovf(rnd);
				end
				OP_AH0: acc_q <= rnd;
				OP_BSQ: acc_q <= acc_q - rnd;
				OP_DS: begin
					y_q <= sat_data(sum);
					ov_q <= ov_q || sat_ovf(sum);
				end
				default: ;
			endcase
		end
		if (cmd.commit) begin
			out_y_q <= y_q;
			out_u_q <= u_q;
			out_ov_q <= ov_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist0_q <= '0;
			hist1_q <= '0;
			hist2_q <= '0;
			prev_drive_q <= RST_DRIVE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				hist2_q <= hist1_q;
				hist1_q <= hist0_q;
				hist0_q <= y_q;
				prev_drive_q <= u_q;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_plant_output = out_y_q;
	assign out_drive = out_u_q;
	assign out_overflow = out_ov_q;

endmodule

FILE: rtl/pwnp_ctrl.sv
// Controller state machine that sequences the multiply-accumulate steps of one tick.
module pwnp_ctrl
	import pwnp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	ctrl_state_t state_q, state_d;
	mul_op_t op_q;
	logic stall;

	assign stall = (op_q == OP_DS) && !status.sin_done;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_MUL;
			ST_MUL: if (!stall) state_d = ST_ACC;
			ST_ACC: state_d = (op_q == OP_DS) ? ST_DONE : ST_MUL;
			ST_DONE: if (status.out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd.load = 1'b0;
		cmd.mul = 1'b0;
		cmd.acc = 1'b0;
		cmd.commit = 1'b0;
		cmd.op = op_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_MUL: cmd.mul = !stall;
			ST_ACC: cmd.acc = 1'b1;
			ST_DONE: cmd.commit = status.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_Q0E0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				op_q <= OP_Q0E0;
			end else if (state_q == ST_ACC && op_q != OP_DS) begin
				op_q <= mul_op_t'(op_q + 3'd1);
			end
		end
	end

endmodule

FILE: rtl/pid_with_nonlinear_plant_step_unit.sv
// Top level of the velocity-form PID step unit closed around a nonlinear plant.
//
// Each transaction on the s_axis channel carries one setpoint and runs one control
// tick. The unit forms three errors against the stored plant outputs, updates the
// drive with the weighted error sum, advances the plant model and returns one
// transaction on the m_axis channel holding the new plant output, the drive and an
// overflow flag. All values are signed Q8.24 and saturate on overflow.
// A tick runs from acceptance to the result appearing on m_axis, and the next
// setpoint is accepted only after that tick has finished. The length is set by
// the sine of the previous drive: six reduction steps and a 24-step CORDIC in one
// iterative unit, while a single shared 32x32 multiplier handles the eight products.
// The result sits in an output register, so a new setpoint is taken while it waits;
// if the receiver still stalls when the next tick finishes, that tick holds until
// the register frees. Coefficients are written through the cfg channel, which is
// always ready; writes are meant for times when no tick is in progress.
// Reset restores the default coefficients, clears the output history, sets the
// previous drive to 1.0 and empties the output register.
module pid_with_nonlinear_plant_step_unit
	import pwnp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [31:0]      s_axis_tdata,  // [31:0] setpoint
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [63:0]      m_axis_tdata,  // [31:0] plant_output, [63:32] drive
	output logic             m_axis_tuser,  // [0] overflow
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [31:0]      cfg_data
);

	ctrl_cmd_t cmd;
	dp_status_t status;
	data_t y_out, u_out;

	assign cfg_ready = 1'b1;

	pwnp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	pwnp_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.setpoint         (s_axis_tdata),
		.cfg_we           (cfg_valid && cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.out_valid        (m_axis_tvalid),
		.out_ready        (m_axis_tready),
		.out_plant_output (y_out),
		.out_drive        (u_out),
		.out_overflow     (m_axis_tuser)
	);

	assign m_axis_tdata = {u_out, y_out};

endmodule

FILE: sim/tb_pid_with_nonlinear_plant_step_unit.sv
// Self-checking testbench for the PID step unit: a predictor and scoreboard check every result.
module tb_pid_with_nonlinear_plant_step_unit;
	import pwnp_pkg::*;

	localparam int FRAC = 24;
	localparam int TICK_LIMIT = 1000000;
	localparam int NUM_COEFF = REG_PLANT_D + 1;
	localparam logic [IDX_W-1:0] REG_UNUSED = '1;
	localparam data_t Q_ONE = 32'sh0100_0000;
	localparam data_t Q_HALF = 32'sh0080_0000;
	localparam data_t D_MAX = 32'sh7fff_ffff;
	localparam data_t D_MIN = 32'sh8000_0000;
	localparam longint ROUND_BIT = 64'sd1 <<< (FRAC - 1);
	localparam longint LIM_HI = 64'sd2147483647;
	localparam longint LIM_LO = -64'sd2147483648;
	localparam longint ROT_GAIN = 64'sd652032874;
	localparam longint TWO_PI = 64'sd6746518852;
	localparam longint PI = 64'sd3373259426;
	localparam longint HALF_PI = 64'sd1686629713;
	localparam longint ATAN_TABLE [24] = '{
		843314856, 497837829, 263043836, 133525158, 67021686,
		33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
		524287, 262143, 131071, 65535, 32767, 16383, 8191,
		4095, 2047, 1023, 511, 255, 127
	};
	localparam longint DEFAULT_COEFF [NUM_COEFF] = '{
		169450, -337206, 167772, 12113150, 7063208, 9848226, 587203
	};
	localparam data_t WARMUP [14] = '{
		32'sd0, Q_ONE, Q_ONE, Q_ONE, -Q_ONE, D_MAX, D_MAX, D_MIN, D_MIN,
		32'sd1, -32'sd1, 32'sh5555_5555, 32'shAAAA_AAAA, Q_HALF
	};
	localparam data_t SLAM [10] = '{
		D_MAX, D_MAX, D_MIN, D_MIN, D_MAX, 32'sd0, D_MIN, Q_ONE, -Q_ONE, D_MAX
	};

	typedef enum {
		PLAN_KEEP,
		PLAN_MODERATE,
		PLAN_FULL,
		PLAN_MIN,
		PLAN_MAX,
		PLAN_ZERO,
		PLAN_TUNED
	} coeff_plan_t;

	typedef struct packed {
		data_t y;
		data_t u;
		logic  ov;
	} tick_t;

	class loop_tracker;
		longint coeff [NUM_COEFF];
		longint y_hist [3];
		longint u_prev;
		tick_t pending_ticks [$];
		int failures;
		int ticks_checked;

		function new();
			for (int i = 0; i < NUM_COEFF; i++) begin
				coeff[i] = DEFAULT_COEFF[i];
			end
			y_hist = '{0, 0, 0};
			u_prev = 64'sd1 <<< FRAC;
			failures = 0;
			ticks_checked = 0;
		endfunction

		function void set_coeff(logic [IDX_W-1:0] idx, data_t val);
			if (idx <= REG_PLANT_D) begin
				coeff[idx] = val;
			end
		endfunction

		function int outstanding();
			return pending_ticks.size();
		endfunction

		function longint clip(longint x, inout bit ov);
			if (x > LIM_HI) begin
				ov = 1'b1;
				return LIM_HI;
			end
			if (x < LIM_LO) begin
				ov = 1'b1;
				return LIM_LO;
			end
			return x;
		endfunction

		function longint mul_round(longint a, longint b);
			return (a * b + ROUND_BIT) >>> FRAC;
		endfunction

		function longint sine(longint ang);
			longint z;
			longint x;
			longint y;
			longint dx;
			longint dy;
			longint r;
			z = ang <<< (30 - FRAC);
			z = z % TWO_PI;
			if (z < 0) z = z + TWO_PI;
			if (z > PI) z = z - TWO_PI;
			if (z > HALF_PI) begin
				z = PI - z;
			end else if (z < -HALF_PI) begin
				z = -PI - z;
			end
			x = ROT_GAIN;
			y = 0;
			for (int i = 0; i < 24; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x = x - dx;
					y = y + dy;
					z = z - ATAN_TABLE[i];
				end else begin
					x = x + dx;
					y = y - dy;
					z = z + ATAN_TABLE[i];
				end
			end
			r = (y + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
			if (r > (64'sd1 <<< FRAC)) r = 64'sd1 <<< FRAC;
			if (r < -(64'sd1 <<< FRAC)) r = -(64'sd1 <<< FRAC);
			return r;
		endfunction

		function void note_setpoint(data_t sp);
			bit ov;
			longint e0;
			longint e1;
			longint e2;
			longint u;
			longint sq;
			longint y;
			tick_t t;
			ov = 1'b0;
			e0 = clip(longint'(sp) - y_hist[0], ov);
			e1 = clip(longint'(sp) - y_hist[1], ov);
			e2 = clip(longint'(sp) - y_hist[2], ov);
			u = clip(u_prev + mul_round(coeff[REG_GAIN_Q0], e0)
				+ mul_round(coeff[REG_GAIN_Q1], e1)
				+ mul_round(coeff[REG_GAIN_Q2], e2), ov);
			sq = clip(mul_round(y_hist[1], y_hist[1]), ov);
			y = clip(mul_round(coeff[REG_PLANT_A], y_hist[0])
				- mul_round(coeff[REG_PLANT_B], sq)
				+ mul_round(coeff[REG_PLANT_C], u)
				+ mul_round(coeff[REG_PLANT_D], sine(u_prev)), ov);
			y_hist[2] = y_hist[1];
			y_hist[1] = y_hist[0];
			y_hist[0] = y;
			u_prev = u;
			t.y = data_t'(y);
			t.u = data_t'(u);
			t.ov = ov;
			pending_ticks = {pending_ticks, t};
		endfunction

		task report(string what, longint got, longint want);
			if (failures < 100) begin
				$display("mismatch on tick %0d, %s: got %0d, expected %0d",
					ticks_checked, what, got, want);
			end
			failures++;
		endtask

		task check_tick(data_t y, data_t u, logic ov);
			tick_t want;
			if (pending_ticks.size() == 0) begin
				report("result with no tick outstanding, plant_output", y, 0);
				return;
			end
			want = pending_ticks.pop_front();
			if (y !== want.y) report("plant_output", y, want.y);
			if (u !== want.u) report("drive", u, want.u);
			if (ov !== want.ov) report("overflow", ov, want.ov);
			ticks_checked++;
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic m_axis_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	loop_tracker tracker = new();
	data_t coeff_plan [NUM_COEFF];
	data_t held_setpoint = '0;
	int src_idle_pct = 10;
	int sink_idle_pct = 47;
	int accepted_setpoints = 0;
	int cycles = 0;
	logic sink_hold = 1'b0;

	pid_with_nonlinear_plant_step_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= TICK_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			tracker.check_tick(data_t'(m_axis_tdata[31:0]), data_t'(m_axis_tdata[63:32]),
				m_axis_tuser);
		end
		m_axis_tready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
	end

	// Holds the result side off long enough for the unit to back up into its input.
	initial begin : sink_hold_off
		wait (accepted_setpoints >= 250);
		@(posedge clk);
		sink_hold <= 1'b1;
		repeat (400) @(posedge clk);
		sink_hold <= 1'b0;
		wait (accepted_setpoints >= 1700);
		@(posedge clk);
		sink_hold <= 1'b1;
		repeat (600) @(posedge clk);
		sink_hold <= 1'b0;
	end

	function automatic data_t pick_setpoint(input data_t held);
		int pick;
		pick = $urandom_range(99);
		if (pick < 35) return held;
		if (pick < 70) return data_t'(int'($urandom_range(32'h0400_0000)) - 32'sh0200_0000);
		if (pick < 90) return data_t'($urandom);
		if (pick < 94) return D_MAX;
		if (pick < 98) return D_MIN;
		return '0;
	endfunction

	task automatic send_setpoint(input data_t sp);
		int gap;
		gap = 0;
		while ($urandom_range(99) < src_idle_pct) gap++;
		if (src_idle_pct != 0 && $urandom_range(99) < 3) gap += $urandom_range(80);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= sp;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		tracker.note_setpoint(sp);
		accepted_setpoints++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_coeffs(input bit poke_unused);
		for (int i = REG_GAIN_Q0; i <= REG_PLANT_D; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= IDX_W'(i);
			cfg_data <= coeff_plan[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			tracker.set_coeff(IDX_W'(i), coeff_plan[i]);
		end
		if (poke_unused) begin
			cfg_index <= REG_UNUSED;
			cfg_data <= $urandom;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			tracker.set_coeff(REG_UNUSED, data_t'(cfg_data));
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input coeff_plan_t plan, input int count);
		drain();
		if (plan != PLAN_KEEP) begin
			for (int i = 0; i < NUM_COEFF; i++) begin
				case (plan)
					PLAN_MODERATE: begin
						coeff_plan[i] = data_t'(int'($urandom_range(32'h0400_0000)) - 32'sh0200_0000);
					end
					PLAN_FULL: coeff_plan[i] = data_t'($urandom);
					PLAN_MIN: coeff_plan[i] = D_MIN;
					PLAN_MAX: coeff_plan[i] = D_MAX;
					PLAN_ZERO: coeff_plan[i] = '0;
					default: begin
						coeff_plan[i] = data_t'(DEFAULT_COEFF[i]
							* longint'($urandom_range(75, 125)) / 100);
					end
				endcase
			end
			load_coeffs(plan == PLAN_FULL);
		end
		repeat (count) begin
			held_setpoint = pick_setpoint(held_setpoint);
			send_setpoint(held_setpoint);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		foreach (WARMUP[i]) send_setpoint(WARMUP[i]);
		run_phase(PLAN_KEEP, 300);
		run_phase(PLAN_MAX, 0);
		foreach (SLAM[i]) send_setpoint(SLAM[i]);
		run_phase(PLAN_KEEP, 100);
		run_phase(PLAN_MODERATE, 300);

		drain();
		src_idle_pct = 47;
		sink_idle_pct <= 10;
		run_phase(PLAN_FULL, 250);
		run_phase(PLAN_MIN, 100);
		run_phase(PLAN_ZERO, 80);

		drain();
		src_idle_pct = 0;
		sink_idle_pct <= 0;
		run_phase(PLAN_TUNED, 500);
		run_phase(PLAN_MODERATE, 300);

		drain();
		repeat (80) @(posedge clk);
		if (tracker.failures == 0 && tracker.outstanding() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
